@@ design/opbsr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opbsr_pkg
// Shared types and constants for the child octant point binning block.
// ============================================================================
package opbsr_pkg;

    // Field widths fixed by the item formats.
    localparam int COORD_W   = 32;
    localparam int HALF_W    = 30;
    localparam int SIZE_W    = 32;
    localparam int TOTAL_W   = 17;
    localparam int OCTET_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_HALF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHILD_OCTET = 3'd4;

    // Input item: one curvature point.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      point_ok;
        logic [SIZE_W-1:0]         point_size;
        logic                      final_point;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic                inside_box;
        logic                summary_valid;
        logic [TOTAL_W-1:0]  inside_total;
        logic [TOTAL_W-1:0]  valid_total;
        logic [SIZE_W-1:0]   mean_size;
        logic                size_known;
        logic                must_split;
        logic                on_boundary;
    } out_item_t;

    // Classified point handed from the front part to the back part.
    typedef struct packed {
        logic              in_box;
        logic              ok;
        logic [SIZE_W-1:0] size;
        logic              last;
    } class_item_t;

    // Back part sequencer states.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_SEND
    } back_state_t;

endpackage

@@ design/opbsr_fifo.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opbsr_fifo
// Small synchronous queue with full and empty flags and a show-ahead read.
// ============================================================================
module opbsr_fifo #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer and fill count update; pointers wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

endmodule

@@ design/opbsr_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opbsr_front
// Configuration registers and the child box test for each incoming point.
// ============================================================================
module opbsr_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    input  logic [opbsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [opbsr_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  opbsr_pkg::in_item_t                   point,
    output opbsr_pkg::class_item_t                item
);

    logic signed [opbsr_pkg::COORD_W-1:0] parent_x_reg, parent_x_next;
    logic signed [opbsr_pkg::COORD_W-1:0] parent_y_reg, parent_y_next;
    logic signed [opbsr_pkg::COORD_W-1:0] parent_z_reg, parent_z_next;
    logic [opbsr_pkg::HALF_W-1:0]         parent_half_reg, parent_half_next;
    logic [opbsr_pkg::OCTET_W-1:0]        child_octet_reg, child_octet_next;
    logic                                 in_x, in_y, in_z;

    // Closed interval test on one axis, done at 34 bits so no sum can wrap.
    function automatic logic axis_in(
        input logic signed [opbsr_pkg::COORD_W-1:0] p,
        input logic signed [opbsr_pkg::COORD_W-1:0] c,
        input logic [opbsr_pkg::HALF_W-1:0]         h,
        input logic                                 plus
    );
        logic signed [opbsr_pkg::COORD_W+1:0] p_w;
        logic signed [opbsr_pkg::COORD_W+1:0] c_w;
        logic signed [opbsr_pkg::COORD_W+1:0] h_w;
        logic signed [opbsr_pkg::COORD_W+1:0] lo_w;
        logic signed [opbsr_pkg::COORD_W+1:0] hi_w;
        p_w = {{2{p[opbsr_pkg::COORD_W-1]}}, p};
        c_w = {{2{c[opbsr_pkg::COORD_W-1]}}, c};
        h_w = {4'b0000, h};
        lo_w = plus ? c_w : c_w - h_w;
        hi_w = plus ? c_w + h_w : c_w;
        return (p_w >= lo_w) && (p_w <= hi_w);
    endfunction

    // Register writes by index; indexes past the list are dropped.
    always_comb
    begin
        parent_x_next    = parent_x_reg;
        parent_y_next    = parent_y_reg;
        parent_z_next    = parent_z_reg;
        parent_half_next = parent_half_reg;
        child_octet_next = child_octet_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                opbsr_pkg::CFG_PARENT_X:    parent_x_next    = cfg_data;
                opbsr_pkg::CFG_PARENT_Y:    parent_y_next    = cfg_data;
                opbsr_pkg::CFG_PARENT_Z:    parent_z_next    = cfg_data;
                opbsr_pkg::CFG_PARENT_HALF:
                    parent_half_next = cfg_data[opbsr_pkg::HALF_W-1:0];
                opbsr_pkg::CFG_CHILD_OCTET:
                    child_octet_next = cfg_data[opbsr_pkg::OCTET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parent_x_reg    <= '0;
            parent_y_reg    <= '0;
            parent_z_reg    <= '0;
            parent_half_reg <= opbsr_pkg::HALF_W'(65536);
            child_octet_reg <= '0;
        end
        else
        begin
            parent_x_reg    <= parent_x_next;
            parent_y_reg    <= parent_y_next;
            parent_z_reg    <= parent_z_next;
            parent_half_reg <= parent_half_next;
            child_octet_reg <= child_octet_next;
        end
    end

    // Box test on all three axes in parallel.
    assign in_x = axis_in(point.point_x, parent_x_reg, parent_half_reg, child_octet_reg[0]);
    assign in_y = axis_in(point.point_y, parent_y_reg, parent_half_reg, child_octet_reg[1]);
    assign in_z = axis_in(point.point_z, parent_z_reg, parent_half_reg, child_octet_reg[2]);

    assign item.in_box = in_x && in_y && in_z;
    assign item.ok     = point.point_ok;
    assign item.size   = point.point_size;
    assign item.last   = point.final_point;

endmodule

@@ design/opbsr_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opbsr_back
// Size accumulators, the mean divider and result assembly.
// ============================================================================
module opbsr_back #(
    parameter int MAX_POINTS = 65536
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  opbsr_pkg::class_item_t  item,
    input  logic                    item_empty,
    output logic                    item_pop,
    input  logic                    res_full,
    output logic                    res_push,
    output opbsr_pkg::out_item_t    res
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = opbsr_pkg::SIZE_W + CNT_W;
    localparam int DIV_W = CNT_W + opbsr_pkg::SIZE_W - 1;
    localparam int STEP_W = $clog2(opbsr_pkg::SIZE_W);
    localparam int EXT_W = opbsr_pkg::TOTAL_W + CNT_W;
    localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_POINTS);
    localparam logic [STEP_W-1:0] LastStep = STEP_W'(opbsr_pkg::SIZE_W - 1);

    opbsr_pkg::back_state_t state_reg, state_next;

    logic [SUM_W-1:0]            size_sum_reg, size_sum_next;
    logic [opbsr_pkg::SIZE_W-1:0] size_max_reg, size_max_next;
    logic [opbsr_pkg::SIZE_W-1:0] size_min_reg, size_min_next;
    logic [CNT_W-1:0]            inside_cnt_reg, inside_cnt_next;
    logic [CNT_W-1:0]            valid_cnt_reg, valid_cnt_next;
    logic                        fin_inside_reg, fin_inside_next;

    logic [SUM_W-1:0]             rem_reg, rem_next;
    logic [DIV_W-1:0]             div_reg, div_next;
    logic [opbsr_pkg::SIZE_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0]            step_reg, step_next;

    logic                         acc_en;
    logic                         rem_ge;
    logic [SUM_W-1:0]             div_ext;
    logic [EXT_W-1:0]             inside_ext;
    logic [EXT_W-1:0]             valid_ext;
    logic [opbsr_pkg::SIZE_W+3:0] max_x10;
    logic [opbsr_pkg::SIZE_W+3:0] min_x11;
    logic                         size_known;

    // Accumulate only inside points while the count has room.
    assign acc_en = item.in_box && (inside_cnt_reg < MaxCount);

    // One restoring divider step: quotient fits in the size width.
    assign div_ext = SUM_W'(div_reg);
    assign rem_ge  = (rem_reg >= div_ext);

    // Summary fields from the settled accumulators.
    assign inside_ext = EXT_W'(inside_cnt_reg);
    assign valid_ext  = EXT_W'(valid_cnt_reg);
    assign max_x10 = {1'b0, size_max_reg, 3'b000} + {3'b000, size_max_reg, 1'b0};
    assign min_x11 = {1'b0, size_min_reg, 3'b000} + {3'b000, size_min_reg, 1'b0}
                     + {4'b0000, size_min_reg};
    assign size_known = (valid_cnt_reg != '0);

    // Sequencer: stream points, divide on the final one, then send the summary.
    always_comb
    begin
        state_next      = state_reg;
        size_sum_next   = size_sum_reg;
        size_max_next   = size_max_reg;
        size_min_next   = size_min_reg;
        inside_cnt_next = inside_cnt_reg;
        valid_cnt_next  = valid_cnt_reg;
        fin_inside_next = fin_inside_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        item_pop        = 1'b0;
        res_push        = 1'b0;
        res             = '0;

        case (state_reg)
            opbsr_pkg::ST_RUN:
            begin
                if (!item_empty && !res_full)
                begin
                    item_pop = 1'b1;
                    if (acc_en)
                    begin
                        inside_cnt_next = inside_cnt_reg + 1'b1;
                        if (item.ok)
                        begin
                            valid_cnt_next = valid_cnt_reg + 1'b1;
                            size_sum_next  = size_sum_reg + SUM_W'(item.size);
                            if (item.size > size_max_reg)
                            begin
                                size_max_next = item.size;
                            end
                            if (item.size < size_min_reg)
                            begin
                                size_min_next = item.size;
                            end
                        end
                    end
                    if (item.last)
                    begin
                        fin_inside_next = item.in_box;
                        rem_next  = size_sum_next;
                        div_next  = {valid_cnt_next, {(opbsr_pkg::SIZE_W - 1){1'b0}}};
                        quo_next  = '0;
                        step_next = '0;
                        state_next = (valid_cnt_next == '0) ? opbsr_pkg::ST_SEND
                                                            : opbsr_pkg::ST_DIV;
                    end
                    else
                    begin
                        res_push       = 1'b1;
                        res.inside_box = item.in_box;
                    end
                end
            end

            opbsr_pkg::ST_DIV:
            begin
                if (rem_ge)
                begin
                    rem_next = rem_reg - div_ext;
                end
                quo_next  = {quo_reg[opbsr_pkg::SIZE_W-2:0], rem_ge};
                div_next  = div_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == LastStep)
                begin
                    state_next = opbsr_pkg::ST_SEND;
                end
            end

            opbsr_pkg::ST_SEND:
            begin
                if (!res_full)
                begin
                    res_push          = 1'b1;
                    res.inside_box    = fin_inside_reg;
                    res.summary_valid = 1'b1;
                    res.inside_total  = inside_ext[opbsr_pkg::TOTAL_W-1:0];
                    res.valid_total   = valid_ext[opbsr_pkg::TOTAL_W-1:0];
                    res.mean_size     = size_known ? quo_reg : '0;
                    res.size_known    = size_known;
                    res.must_split    = size_known && (max_x10 > min_x11);
                    res.on_boundary   = (inside_cnt_reg != '0);
                    size_sum_next     = '0;
                    size_max_next     = '0;
                    size_min_next     = '1;
                    inside_cnt_next   = '0;
                    valid_cnt_next    = '0;
                    state_next        = opbsr_pkg::ST_RUN;
                end
            end

            default:
            begin
                state_next = opbsr_pkg::ST_RUN;
            end
        endcase
    end

    // Control state and accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= opbsr_pkg::ST_RUN;
            size_sum_reg   <= '0;
            size_max_reg   <= '0;
            size_min_reg   <= '1;
            inside_cnt_reg <= '0;
            valid_cnt_reg  <= '0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            size_sum_reg   <= size_sum_next;
            size_max_reg   <= size_max_next;
            size_min_reg   <= size_min_next;
            inside_cnt_reg <= inside_cnt_next;
            valid_cnt_reg  <= valid_cnt_next;
            step_reg       <= step_next;
        end
    end

    // Divider datapath and the held final flag.
    always_ff @(posedge clk)
    begin
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        fin_inside_reg <= fin_inside_next;
    end

    // A result is only written when the output queue has room.
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result written into a full queue");

    // Points are only taken while streaming.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (state_reg == opbsr_pkg::ST_RUN))
        else $error("point taken while the summary is pending");

    // A summary leaves the accumulators cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.summary_valid) |=>
        (inside_cnt_reg == '0 && valid_cnt_reg == '0 && size_sum_reg == '0))
        else $error("accumulators not cleared after a summary");

    // Valid inside points are a subset of inside points.
    assert property (@(posedge clk) disable iff (!rst_n) valid_cnt_reg <= inside_cnt_reg)
        else $error("valid count exceeds inside count");

endmodule

@@ design/octant_point_bin_and_size_reduce_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// octant_point_bin_and_size_reduce_top
// Bins curvature points into a child octant and reduces their size values.
// ============================================================================
// Usage: write the parent center, parent half edge and child octet through
// the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// while the block is idle; cfg_ready is always high. Points enter with push
// while full is low. Each point yields one result, read while empty is low
// and taken with pop. The result for a point marked final carries the run
// summary: counts, mean size, split and boundary flags.
// Path: a point is classified on entry and stored in the point queue; the
// back part moves its result into the result queue. A final point's summary
// goes through the divider, skipped if the run had no valid inside point.
// Throughput: one point per cycle while full is low. A final point holds
// the back part for 32 steps of the restoring divider that forms the mean
// one quotient bit per cycle, then while sending the summary; meanwhile the
// classifier keeps filling the queue between the two parts until it is full.
// Reset clears both queues and the accumulators and returns the configuration
// registers to center zero, half edge 1.0 and octet zero.
// When the receiver stalls, the result queue fills, the back part stops,
// then the point queue fills and full rises. No item is lost.
// ============================================================================
module octant_point_bin_and_size_reduce_top #(
    parameter int MAX_POINTS  = 65536,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [opbsr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [opbsr_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  opbsr_pkg::in_item_t               point,
    output logic                              empty,
    input  logic                              pop,
    output opbsr_pkg::out_item_t              result
);

    localparam int CLS_W = $bits(opbsr_pkg::class_item_t);
    localparam int RES_W = $bits(opbsr_pkg::out_item_t);

    opbsr_pkg::class_item_t front_item;
    opbsr_pkg::class_item_t back_item;
    opbsr_pkg::out_item_t   back_res;
    logic [CLS_W-1:0]       mid_rd_data;
    logic [RES_W-1:0]       res_rd_data;
    logic                   mid_full, mid_empty, mid_wr, mid_rd;
    logic                   res_full, res_wr, res_rd;

    assign cfg_ready = 1'b1;

    // Classifier and configuration registers.
    opbsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point),
        .item      (front_item)
    );

    // Queue of classified points between the two parts.
    assign mid_wr = push && !mid_full;
    assign full   = mid_full;

    opbsr_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_wr),
        .wr_data (front_item),
        .rd_en   (mid_rd),
        .rd_data (mid_rd_data),
        .full    (mid_full),
        .empty   (mid_empty)
    );

    assign back_item = mid_rd_data;

    // Accumulators, divider and result assembly.
    opbsr_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_empty (mid_empty),
        .item_pop   (mid_rd),
        .res_full   (res_full),
        .res_push   (res_wr),
        .res        (back_res)
    );

    // Result queue toward the receiver.
    assign res_rd = pop && !empty;

    opbsr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (back_res),
        .rd_en   (res_rd),
        .rd_data (res_rd_data),
        .full    (res_full),
        .empty   (empty)
    );

    assign result = res_rd_data;

endmodule

@@ bench/tb_octant_point_bin_and_size_reduce_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_octant_point_bin_and_size_reduce_top
// Self-checking bench for the child octant point binning block.
// Each point item is scored by a local predictor that bins it against the
// child box and keeps the running size statistics. The predicted results
// wait in a queue, and every result popped from the block is compared
// field by field with the oldest one. Directed tests cover reset values,
// ratio and zero corner cases, all octets with extreme boxes and output back
// pressure. A long random stream of point runs follows, with a new box every
// few dozen items.
// ============================================================================
module tb_octant_point_bin_and_size_reduce_top;

    localparam int CLK_PERIOD   = 10;
    localparam int COUNT_CAP    = 65536;
    localparam int HOLD_LEN     = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 580;
    localparam int TAIL_CYCLES  = 10;
    localparam longint COORD_MIN = -64'sh8000_0000;
    localparam longint COORD_MAX = 64'sh7FFF_FFFF;

    // Point classes used when building coordinates on one axis.
    localparam int K_INSIDE  = 0;
    localparam int K_LOW     = 1;
    localparam int K_HIGH    = 2;
    localparam int K_BELOW   = 3;
    localparam int K_ABOVE   = 4;
    localparam int K_ANY     = 5;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [opbsr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [opbsr_pkg::CFG_DAT_W-1:0] cfg_data;
    logic                            push;
    logic                            full;
    opbsr_pkg::in_item_t             point;
    logic                            empty;
    logic                            pop;
    opbsr_pkg::out_item_t            result;

    // Predictor copy of the box and the running statistics.
    longint      ctr_x, ctr_y, ctr_z;
    longint      half_len;
    logic [2:0]  octet;
    logic [63:0] size_total, size_hi, size_lo;
    int          inside_cnt, valid_cnt;

    opbsr_pkg::out_item_t point_outcomes[$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic quiet       = 1'b0;
    logic push_on     = 1'b0;

    octant_point_bin_and_size_reduce_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .point     (point),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_sums();
        size_total = '0;
        size_hi    = '0;
        size_lo    = 64'hFFFF_FFFF;
        inside_cnt = 0;
        valid_cnt  = 0;
    endfunction

    function automatic void reset_model();
        ctr_x    = 0;
        ctr_y    = 0;
        ctr_z    = 0;
        half_len = 65536;
        octet    = '0;
        clear_sums();
    endfunction

    // Closed interval test on one axis: [c, c+h] on the plus side, else [c-h, c].
    function automatic logic axis_hit(longint p, longint c, logic plus_side);
        if (plus_side)
            return (p >= c) && (p <= c + half_len);
        return (p >= c - half_len) && (p <= c);
    endfunction

    function automatic opbsr_pkg::out_item_t reduce_point(opbsr_pkg::in_item_t p);
        opbsr_pkg::out_item_t r;
        logic                 hit;
        r   = '0;
        hit = axis_hit(longint'($signed(p.point_x)), ctr_x, octet[0]) &&
              axis_hit(longint'($signed(p.point_y)), ctr_y, octet[1]) &&
              axis_hit(longint'($signed(p.point_z)), ctr_z, octet[2]);

        // Inside points stop accumulating once the count limit is reached.
        if (hit && inside_cnt < COUNT_CAP)
        begin
            inside_cnt++;
            if (p.point_ok)
            begin
                if (64'(p.point_size) > size_hi)
                    size_hi = 64'(p.point_size);
                if (64'(p.point_size) < size_lo)
                    size_lo = 64'(p.point_size);
                size_total += 64'(p.point_size);
                valid_cnt++;
            end
        end

        r.inside_box = hit;

        // The final point is counted first, then the run summary goes out.
        if (p.final_point)
        begin
            r.summary_valid = 1'b1;
            r.inside_total  = inside_cnt[opbsr_pkg::TOTAL_W-1:0];
            r.valid_total   = valid_cnt[opbsr_pkg::TOTAL_W-1:0];
            if (valid_cnt > 0)
            begin
                r.mean_size  = 32'(size_total / 64'(valid_cnt));
                r.size_known = 1'b1;
                r.must_split = (size_hi * 64'd10) > (size_lo * 64'd11);
            end
            r.on_boundary = (inside_cnt > 0);
            clear_sums();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result(opbsr_pkg::out_item_t got);
        opbsr_pkg::out_item_t want;
        if (point_outcomes.size() == 0)
        begin
            $error("result popped with no point outstanding");
            fail_count++;
            return;
        end
        want = point_outcomes.pop_front();
        check_field("inside_box", want.inside_box, got.inside_box);
        check_field("summary_valid", want.summary_valid, got.summary_valid);
        check_field("inside_total", want.inside_total, got.inside_total);
        check_field("valid_total", want.valid_total, got.valid_total);
        check_field("mean_size", want.mean_size, got.mean_size);
        check_field("size_known", want.size_known, got.size_known);
        check_field("must_split", want.must_split, got.must_split);
        check_field("on_boundary", want.on_boundary, got.on_boundary);
    endfunction

    // Result side: pops with random stalls and one long hold when requested.
    initial
    begin
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_result(result);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
                pop <= 1'b0;
            end
            else
                pop <= quiet || ($urandom_range(99) >= 7);
        end
    end

    // Cycle limit guard.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("cycle limit reached with %0d results outstanding", point_outcomes.size());
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic stop_push();
        if (push_on)
        begin
            push <= 1'b0;
            push_on = 1'b0;
        end
    endtask

    // Offers one point item, with random idle cycles ahead of it.
    task automatic send_point(input opbsr_pkg::in_item_t p);
        while (!quiet && $urandom_range(99) < 7)
        begin
            stop_push();
            @(posedge clk);
        end
        push <= 1'b1;
        push_on = 1'b1;
        point <= p;
        @(posedge clk);
        while (full)
            @(posedge clk);
        point_outcomes.insert(point_outcomes.size(), reduce_point(p));
    endtask

    task automatic wait_drained();
        stop_push();
        while (point_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [opbsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [opbsr_pkg::CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            opbsr_pkg::CFG_PARENT_X:    ctr_x = longint'($signed(data));
            opbsr_pkg::CFG_PARENT_Y:    ctr_y = longint'($signed(data));
            opbsr_pkg::CFG_PARENT_Z:    ctr_z = longint'($signed(data));
            opbsr_pkg::CFG_PARENT_HALF: half_len = longint'(data[opbsr_pkg::HALF_W-1:0]);
            opbsr_pkg::CFG_CHILD_OCTET: octet = data[opbsr_pkg::OCTET_W-1:0];
            default: ;
        endcase
    endtask

    // Writes all five registers once the block has returned every result.
    // Unused upper bits of the half edge and octet words carry random junk.
    task automatic set_config(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [31:0] hl,
                              input logic [2:0] oc);
        logic [31:0] junk;
        junk = $urandom;
        wait_drained();
        write_reg(opbsr_pkg::CFG_PARENT_X, x);
        write_reg(opbsr_pkg::CFG_PARENT_Y, y);
        write_reg(opbsr_pkg::CFG_PARENT_Z, z);
        write_reg(opbsr_pkg::CFG_PARENT_HALF, {junk[31:30], hl[29:0]});
        write_reg(opbsr_pkg::CFG_CHILD_OCTET, {junk[28:0], oc});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Picks a coordinate relative to the child interval on one axis.
    function automatic logic [31:0] pick_coord(longint c, logic plus_side, int kind);
        longint lo, hi, v;
        lo = plus_side ? c : c - half_len;
        hi = plus_side ? c + half_len : c;
        if (lo < COORD_MIN)
            lo = COORD_MIN;
        if (hi > COORD_MAX)
            hi = COORD_MAX;
        case (kind)
            K_INSIDE: v = lo + longint'($urandom_range(32'(hi - lo)));
            K_LOW:    v = lo;
            K_HIGH:   v = hi;
            K_BELOW:  v = lo - 1;
            K_ABOVE:  v = hi + 1;
            default:  v = longint'($signed($urandom));
        endcase
        // An edge neighbor beyond the coordinate range falls back to noise.
        if (v < COORD_MIN || v > COORD_MAX)
            v = longint'($signed($urandom));
        return v[31:0];
    endfunction

    function automatic int rand_kind();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return K_INSIDE;
        if (r < 78)
            return K_LOW;
        if (r < 86)
            return K_HIGH;
        if (r < 91)
            return K_BELOW;
        if (r < 96)
            return K_ABOVE;
        return K_ANY;
    endfunction

    function automatic opbsr_pkg::in_item_t make_point(int kx, int ky, int kz, logic ok,
                                                       logic [31:0] sz, logic fin);
        opbsr_pkg::in_item_t p;
        p.point_x     = pick_coord(ctr_x, octet[0], kx);
        p.point_y     = pick_coord(ctr_y, octet[1], ky);
        p.point_z     = pick_coord(ctr_z, octet[2], kz);
        p.point_ok    = ok;
        p.point_size  = sz;
        p.final_point = fin;
        return p;
    endfunction

    // Sizes cluster around a per-run base so the split flag goes both ways.
    function automatic logic [31:0] rand_size(logic [31:0] base);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 32'd0;
        if (r < 12)
            return 32'hFFFF_FFFF;
        if (r < 30)
            return $urandom;
        return base - (base >> 4) + $urandom_range(base >> 3);
    endfunction

    function automatic logic [31:0] rand_center();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    task automatic random_config();
        logic [31:0] hl;
        case ($urandom_range(5))
            0:       hl = 32'd0;
            1:       hl = 32'h3FFF_FFFF;
            2:       hl = $urandom_range(16);
            default: hl = $urandom_range(32'h0040_0000);
        endcase
        set_config(rand_center(), rand_center(), rand_center(), hl, 3'($urandom));
    endtask

    // One run of points closed by a final point.
    task automatic send_run(input int len);
        logic [31:0] base;
        base = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0010_0000);
        for (int i = 0; i < len; i++)
            send_point(make_point(rand_kind(), rand_kind(), rand_kind(),
                                  $urandom_range(99) < 80, rand_size(base), i == len - 1));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset box is centered at zero, half edge 1.0, minus side on all axes.
    task automatic test_reset_values();
        send_point(make_point(K_LOW, K_LOW, K_LOW, 1'b1, 32'd100, 1'b0));
        send_point(make_point(K_HIGH, K_HIGH, K_HIGH, 1'b1, 32'd110, 1'b0));
        send_point(make_point(K_BELOW, K_INSIDE, K_INSIDE, 1'b1, 32'd500, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_ABOVE, 1'b1, 32'd500, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b0, 32'hFFFF_FFFF, 1'b1));
    endtask

    task automatic test_size_cases();
        set_config(32'h0002_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0001_0000, 3'b101);

        // A ratio of exactly 1.1 does not split.
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd10, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd11, 1'b1));

        // Just above 1.1 splits.
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd10, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd12, 1'b1));

        // A zero minimum with a positive maximum splits.
        send_point(make_point(K_LOW, K_INSIDE, K_HIGH, 1'b1, 32'd0, 1'b0));
        send_point(make_point(K_INSIDE, K_HIGH, K_INSIDE, 1'b1, 32'd5, 1'b1));

        // All-zero sizes give a known mean of zero and no split.
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd0, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd0, 1'b1));

        // Inside points without valid sizes: on the boundary, mean unknown.
        send_point(make_point(K_LOW, K_HIGH, K_INSIDE, 1'b0, 32'd77, 1'b0));
        send_point(make_point(K_BELOW, K_INSIDE, K_INSIDE, 1'b1, 32'd77, 1'b1));

        // A run with no point inside the box.
        send_point(make_point(K_ABOVE, K_INSIDE, K_INSIDE, 1'b1, 32'd9, 1'b1));

        // Largest sizes push the sum past 32 bits.
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_point(make_point(K_INSIDE, K_INSIDE, K_INSIDE, 1'b1, 32'd0, 1'b1));
    endtask

    // Every octet, with centers at the coordinate extremes and the half edge
    // at its maximum or zero. Plus sides sit at the top of the range.
    task automatic test_box_extremes();
        for (int i = 0; i < 8; i++)
        begin
            int k;
            set_config(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                       i[1] ? 32'h7FFF_FFFF : 32'h8000_0000,
                       i[2] ? 32'h7FFF_FFFF : 32'h8000_0000,
                       (i < 4) ? 32'h3FFF_FFFF : 32'd0, 3'(i));
            k = (i % 3 == 0) ? K_BELOW : ((i % 2 == 0) ? K_LOW : K_HIGH);
            send_point(make_point(k, K_HIGH, K_LOW, 1'b1, $urandom, 1'b1));
        end
    endtask

    // The result side holds off for a long stretch while points keep coming.
    task automatic test_back_pressure();
        random_config();
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_run(5);
    endtask

    // Random runs with a fresh box every few dozen items and one stretch
    // with no idling on either side.
    task automatic test_random_stream();
        int sent, len, since_cfg;
        sent      = 0;
        since_cfg = 0;
        random_config();
        while (sent < RANDOM_ITEMS)
        begin
            if (since_cfg >= 80)
            begin
                random_config();
                since_cfg = 0;
            end
            quiet = (sent >= 200 && sent < 350);
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
            send_run(len);
            sent      += len;
            since_cfg += len;
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        push      <= 1'b0;
        point     <= '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_size_cases();
        test_box_extremes();
        test_back_pressure();
        test_random_stream();

        // Let the last results out, then watch for stray ones.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
